>>> rtl/particle_motion_step_defines.svh
// Assertion macros shared by the particle motion RTL.
`ifndef PARTICLE_MOTION_STEP_DEFINES_SVH
`define PARTICLE_MOTION_STEP_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define PMS_ASSERT_SAME(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("pms: same-cycle check failed");

// Check that cond holds in the cycle after trig.
`define PMS_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("pms: next-cycle check failed");

`endif

>>> rtl/pms_pkg.sv
`default_nettype none

package pms_pkg;

  localparam int AXES    = 2;
  localparam int DATA_W  = 32;
  localparam int MASS_W  = 31;
  localparam int CFG_W   = 31;
  localparam int CFG_INDEX_W = 2;
  localparam int QUOT_W  = 32;
  localparam int REM_W   = MASS_W;
  localparam int PROD_W  = 64;
  localparam int TERM_W  = 48;
  localparam int HRES_W  = 61;
  localparam int HMAG_W  = 41;
  localparam int SUM_W   = 50;

  localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_SIZE = 2'd1;

  localparam logic [CFG_W-1:0] TIME_STEP_RESET   = 31'd65536;
  localparam logic [CFG_W-1:0] REGION_SIZE_RESET = 31'd262144;

  localparam logic [DATA_W-1:0] ACC_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] ACC_MIN = 32'h8000_0000;

  // Clamp for the half a*dt^2 magnitude; anything larger saturates the sum anyway.
  localparam logic [HRES_W-1:0] HALF_LIMIT = 61'h100_0000_0000;

  // Sideband that rides alongside the divider.
  typedef struct packed {
    logic [AXES-1:0][DATA_W-1:0] pos;
    logic [AXES-1:0][DATA_W-1:0] vel;
    logic [AXES-1:0][PROD_W-1:0] vprod;
    logic [AXES-1:0]             fneg;
    logic [AXES-1:0]             fzero;
    logic [AXES-1:0]             ovf;
  } carry_t;

  typedef struct packed {
    logic [DATA_W-1:0] new_pos_x;
    logic [DATA_W-1:0] new_pos_y;
    logic [DATA_W-1:0] new_vel_x;
    logic [DATA_W-1:0] new_vel_y;
    logic              left_region;
  } result_t;

  function automatic logic [DATA_W-1:0] sat32(input logic [SUM_W-1:0] v);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = !v[SUM_W-1] && (|v[SUM_W-2:DATA_W-1]);
    neg_ovf = v[SUM_W-1] && !(&v[SUM_W-2:DATA_W-1]);
    if (pos_ovf) begin
      return ACC_MAX;
    end else if (neg_ovf) begin
      return ACC_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/pms_div.sv
`default_nettype none

// Restoring divider, one quotient bit per pipeline stage, both axes share the divisor.
module pms_div #(
  parameter int TAG_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  logic [pms_pkg::AXES-1:0][pms_pkg::REM_W-1:0]  in_rem,
  input  logic [pms_pkg::AXES-1:0][pms_pkg::QUOT_W-1:0] in_low,
  input  logic [pms_pkg::MASS_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic out_valid,
  output logic [pms_pkg::AXES-1:0][pms_pkg::QUOT_W-1:0] out_quot,
  output logic [TAG_W-1:0] out_tag
);

  localparam int STAGES = pms_pkg::QUOT_W;
  localparam int AXES   = pms_pkg::AXES;
  localparam int REM_W  = pms_pkg::REM_W;
  localparam int QUOT_W = pms_pkg::QUOT_W;

  logic                              valid [STAGES];
  logic [AXES-1:0][REM_W-1:0]        rem   [STAGES];
  logic [AXES-1:0][QUOT_W-1:0]       low   [STAGES];
  logic [AXES-1:0][QUOT_W-1:0]       quot  [STAGES];
  logic [pms_pkg::MASS_W-1:0]        den   [STAGES];
  logic [TAG_W-1:0]                  tag   [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                        src_valid;
    logic [AXES-1:0][REM_W-1:0]  src_rem;
    logic [AXES-1:0][QUOT_W-1:0] src_low;
    logic [AXES-1:0][QUOT_W-1:0] src_quot;
    logic [pms_pkg::MASS_W-1:0]  src_den;
    logic [TAG_W-1:0]            src_tag;
    logic [AXES-1:0][REM_W-1:0]  rem_next;
    logic [AXES-1:0][QUOT_W-1:0] low_next;
    logic [AXES-1:0][QUOT_W-1:0] quot_next;

    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_rem   = in_rem;
      assign src_low   = in_low;
      assign src_quot  = '0;
      assign src_den   = in_den;
      assign src_tag   = in_tag;
    end else begin : g_chain
      assign src_valid = valid[k-1];
      assign src_rem   = rem[k-1];
      assign src_low   = low[k-1];
      assign src_quot  = quot[k-1];
      assign src_den   = den[k-1];
      assign src_tag   = tag[k-1];
    end

    always_comb begin
      logic [REM_W:0] trial;
      logic           ge;
      for (int a = 0; a < AXES; a++) begin
        // shift in the next dividend bit, subtract when it fits
        trial = {src_rem[a], src_low[a][QUOT_W-1]};
        ge    = trial >= {1'b0, src_den};
        rem_next[a]  = ge ? REM_W'(trial - {1'b0, src_den}) : trial[REM_W-1:0];
        low_next[a]  = {src_low[a][QUOT_W-2:0], 1'b0};
        quot_next[a] = {src_quot[a][QUOT_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (adv) begin
        valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k]  <= rem_next;
        low[k]  <= low_next;
        quot[k] <= quot_next;
        den[k]  <= src_den;
        tag[k]  <= src_tag;
      end
    end
  end

  assign out_valid = valid[STAGES-1];
  assign out_quot  = quot[STAGES-1];
  assign out_tag   = tag[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/pms_outq.sv
`default_nettype none

`include "particle_motion_step_defines.svh"

// Two-entry output queue between the pipeline and the result channel.
module pms_outq #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_data
);

  localparam int DEPTH = 2;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             pop;

  assign full      = cnt == CNT_W'(DEPTH);
  assign out_valid = cnt != '0;
  assign out_data  = slot[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 1'b1;
    end else if (pop && !push) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  `PMS_ASSERT_SAME(a_no_push_full, clk, rst, push, !full)
  `PMS_ASSERT_NEXT(a_cnt_grow, clk, rst, push && !pop, cnt == $past(cnt) + 1'b1)

endmodule

`default_nettype wire

>>> rtl/particle_motion_step.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------------------------
// input    | in        | in_valid / in_stall    | pos_x pos_y vel_x vel_y force_x force_y body_mass
// result   | out       | out_valid / out_stall  | new_pos_x new_pos_y new_vel_x new_vel_y left_region
// config   | in        | cfg_write              | cfg_index cfg_data
//
// One particle enters per cycle while in_stall is low.
// The 32-stage force/mass divider, one quotient bit per stage, is the bulk of the pipeline.
// Reset clears all valid bits and the queue and loads dt = 1.0 and region = 4.0.
// A two-entry output queue absorbs result stalls; in_stall rises only when it is full,
// and then the whole pipeline holds.
`default_nettype none

`include "particle_motion_step_defines.svh"

module particle_motion_step (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [pms_pkg::DATA_W-1:0] pos_x,
  input  logic signed [pms_pkg::DATA_W-1:0] pos_y,
  input  logic signed [pms_pkg::DATA_W-1:0] vel_x,
  input  logic signed [pms_pkg::DATA_W-1:0] vel_y,
  input  logic signed [pms_pkg::DATA_W-1:0] force_x,
  input  logic signed [pms_pkg::DATA_W-1:0] force_y,
  input  logic [pms_pkg::MASS_W-1:0] body_mass,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [pms_pkg::DATA_W-1:0] new_pos_x,
  output logic signed [pms_pkg::DATA_W-1:0] new_pos_y,
  output logic signed [pms_pkg::DATA_W-1:0] new_vel_x,
  output logic signed [pms_pkg::DATA_W-1:0] new_vel_y,
  output logic left_region,
  input  logic cfg_write,
  input  logic [pms_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pms_pkg::CFG_W-1:0] cfg_data
);

  localparam int AXES   = pms_pkg::AXES;
  localparam int DATA_W = pms_pkg::DATA_W;
  localparam int PROD_W = pms_pkg::PROD_W;
  localparam int TERM_W = pms_pkg::TERM_W;
  localparam int CFG_W  = pms_pkg::CFG_W;
  localparam int HRES_W = pms_pkg::HRES_W;
  localparam int HMAG_W = pms_pkg::HMAG_W;
  localparam int SUM_W  = pms_pkg::SUM_W;
  localparam int DTSQ_W = 2 * CFG_W;
  localparam int HALF_W = DTSQ_W - DATA_W;
  localparam int TAG_W  = $bits(pms_pkg::carry_t);
  localparam int RES_W  = $bits(pms_pkg::result_t);

  // ---------------- configuration ----------------
  logic [CFG_W-1:0]  time_step;
  logic [CFG_W-1:0]  region_size;
  logic [DTSQ_W-1:0] dtsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= pms_pkg::TIME_STEP_RESET;
      region_size <= pms_pkg::REGION_SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pms_pkg::REG_TIME_STEP:   time_step   <= cfg_data;
        pms_pkg::REG_REGION_SIZE: region_size <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dtsq <= time_step * time_step;
  end

  // ---------------- flow control ----------------
  logic adv;
  logic q_full;
  logic accept;

  assign adv      = !q_full;
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // ---------------- stage 1: capture ----------------
  logic                        s1_valid;
  logic [AXES-1:0][DATA_W-1:0] s1_pos;
  logic [AXES-1:0][DATA_W-1:0] s1_vel;
  logic [AXES-1:0][DATA_W-1:0] s1_force;
  logic [pms_pkg::MASS_W-1:0]  s1_mass;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pos   <= {pos_y, pos_x};
      s1_vel   <= {vel_y, vel_x};
      s1_force <= {force_y, force_x};
      s1_mass  <= body_mass;
    end
  end

  // ---------------- stage 2: divider setup, v*dt ----------------
  logic                        s2_valid;
  logic [pms_pkg::MASS_W-1:0]  s2_mass;
  logic [AXES-1:0][DATA_W-1:0] s2_fmag;
  pms_pkg::carry_t             s2_carry;
  logic [AXES-1:0][DATA_W-1:0] fmag;
  pms_pkg::carry_t             carry_next;

  always_comb begin
    carry_next.pos = s1_pos;
    carry_next.vel = s1_vel;
    for (int a = 0; a < AXES; a++) begin
      carry_next.fneg[a]  = s1_force[a][DATA_W-1];
      carry_next.fzero[a] = s1_force[a] == '0;
      fmag[a] = s1_force[a][DATA_W-1] ? DATA_W'(0) - s1_force[a] : s1_force[a];
      // quotient reaches 2^32 exactly when |F| >= m * 2^16
      carry_next.ovf[a] = {16'b0, fmag[a]} >= {1'b0, s1_mass, 16'b0};
      carry_next.vprod[a] = $signed(s1_vel[a]) * $signed({1'b0, time_step});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mass  <= s1_mass;
      s2_fmag  <= fmag;
      s2_carry <= carry_next;
    end
  end

  // ---------------- divider: |F| * 2^16 / m ----------------
  logic [AXES-1:0][pms_pkg::REM_W-1:0]  div_rem;
  logic [AXES-1:0][pms_pkg::QUOT_W-1:0] div_low;
  logic                                 d_valid;
  logic [AXES-1:0][pms_pkg::QUOT_W-1:0] d_quot;
  logic [TAG_W-1:0]                     d_tag;
  pms_pkg::carry_t                      d_carry;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      div_rem[a] = pms_pkg::REM_W'(s2_fmag[a][DATA_W-1:16]);
      div_low[a] = {s2_fmag[a][15:0], 16'b0};
    end
  end

  pms_div #(
    .TAG_W (TAG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s2_valid),
    .in_rem    (div_rem),
    .in_low    (div_low),
    .in_den    (s2_mass),
    .in_tag    (s2_carry),
    .out_valid (d_valid),
    .out_quot  (d_quot),
    .out_tag   (d_tag)
  );

  assign d_carry = d_tag;

  // ---------------- stage 3: acceleration, v*dt term ----------------
  logic                        s3_valid;
  logic [AXES-1:0][DATA_W-1:0] s3_pos;
  logic [AXES-1:0][DATA_W-1:0] s3_vel;
  logic [AXES-1:0][DATA_W-1:0] s3_acc;
  logic [AXES-1:0][TERM_W-1:0] s3_vt;
  logic [AXES-1:0][DATA_W-1:0] acc;
  logic [AXES-1:0][TERM_W-1:0] vt;

  always_comb begin
    logic [PROD_W-1:0] vround;
    for (int a = 0; a < AXES; a++) begin
      if (d_carry.fzero[a]) begin
        acc[a] = '0;
      end else if (d_carry.ovf[a]) begin
        acc[a] = d_carry.fneg[a] ? pms_pkg::ACC_MIN : pms_pkg::ACC_MAX;
      end else if (!d_carry.fneg[a]) begin
        acc[a] = d_quot[a][DATA_W-1] ? pms_pkg::ACC_MAX : d_quot[a];
      end else begin
        acc[a] = (d_quot[a] > pms_pkg::ACC_MIN) ? pms_pkg::ACC_MIN
                                                 : DATA_W'(0) - d_quot[a];
      end
      // round toward zero before dropping the fraction
      vround = d_carry.vprod[a] + {48'b0, {16{d_carry.vprod[a][PROD_W-1]}}};
      vt[a]  = vround[PROD_W-1:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pos <= d_carry.pos;
      s3_vel <= d_carry.vel;
      s3_acc <= acc;
      s3_vt  <= vt;
    end
  end

  // ---------------- stage 4: products with dt and dt^2 ----------------
  logic                                 s4_valid;
  logic [AXES-1:0][DATA_W-1:0]          s4_pos;
  logic [AXES-1:0][DATA_W-1:0]          s4_vel;
  logic [AXES-1:0][TERM_W-1:0]          s4_vt;
  logic [AXES-1:0]                      s4_aneg;
  logic [AXES-1:0][DTSQ_W-1:0]          s4_phi;
  logic [AXES-1:0][PROD_W-1:0]          s4_plo;
  logic [AXES-1:0][PROD_W-1:0]          s4_vaprod;
  logic [AXES-1:0][DTSQ_W-1:0]          phi;
  logic [AXES-1:0][PROD_W-1:0]          plo;
  logic [AXES-1:0][PROD_W-1:0]          vaprod;

  always_comb begin
    logic [DATA_W-1:0] amag;
    for (int a = 0; a < AXES; a++) begin
      amag      = s3_acc[a][DATA_W-1] ? DATA_W'(0) - s3_acc[a] : s3_acc[a];
      phi[a]    = amag * dtsq[DTSQ_W-1:DATA_W];
      plo[a]    = amag * dtsq[DATA_W-1:0];
      vaprod[a] = $signed(s3_acc[a]) * $signed({1'b0, time_step});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_pos    <= s3_pos;
      s4_vel    <= s3_vel;
      s4_vt     <= s3_vt;
      for (int a = 0; a < AXES; a++) begin
        s4_aneg[a] <= s3_acc[a][DATA_W-1];
      end
      s4_phi    <= phi;
      s4_plo    <= plo;
      s4_vaprod <= vaprod;
    end
  end

  // ---------------- stage 5: half term, a*dt term, pos + v*dt ----------------
  logic                          s5_valid;
  logic [AXES-1:0][DATA_W-1:0]   s5_vel;
  logic [AXES-1:0]               s5_aneg;
  logic [AXES-1:0][HRES_W-1:0]   s5_hres;
  logic [AXES-1:0][TERM_W-1:0]   s5_va;
  logic [AXES-1:0][TERM_W:0]     s5_pv;
  logic [AXES-1:0][HRES_W-1:0]   hres;
  logic [AXES-1:0][TERM_W-1:0]   va;
  logic [AXES-1:0][TERM_W:0]     pv;

  always_comb begin
    logic [DTSQ_W+DATA_W-1:0] hsum;
    logic [PROD_W-1:0]        varound;
    for (int a = 0; a < AXES; a++) begin
      // floor(|a| * dt^2 / 2^33) from the split product
      hsum    = {s4_phi[a], 32'b0} + {{HALF_W{1'b0}}, s4_plo[a]};
      hres[a] = hsum[DTSQ_W+DATA_W-1:33];
      varound = s4_vaprod[a] + {48'b0, {16{s4_vaprod[a][PROD_W-1]}}};
      va[a]   = varound[PROD_W-1:16];
      pv[a]   = {{(TERM_W+1-DATA_W){s4_pos[a][DATA_W-1]}}, s4_pos[a]}
              + {s4_vt[a][TERM_W-1], s4_vt[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_vel  <= s4_vel;
      s5_aneg <= s4_aneg;
      s5_hres <= hres;
      s5_va   <= va;
      s5_pv   <= pv;
    end
  end

  // ---------------- stage 6: clamp and sign half term, new velocity sum ----------------
  logic                        s6_valid;
  logic [AXES-1:0][DATA_W-1:0] s6_vel;
  logic [AXES-1:0][TERM_W:0]   s6_pv;
  logic [AXES-1:0][HMAG_W:0]   s6_ht;
  logic [AXES-1:0][TERM_W:0]   s6_nv;
  logic [AXES-1:0][HMAG_W:0]   ht;
  logic [AXES-1:0][TERM_W:0]   nv;

  always_comb begin
    logic [HMAG_W-1:0] hmag;
    for (int a = 0; a < AXES; a++) begin
      hmag  = (s5_hres[a] > pms_pkg::HALF_LIMIT) ? pms_pkg::HALF_LIMIT[HMAG_W-1:0]
                                                 : s5_hres[a][HMAG_W-1:0];
      ht[a] = s5_aneg[a] ? (HMAG_W+1)'(0) - {1'b0, hmag} : {1'b0, hmag};
      nv[a] = {{(TERM_W+1-DATA_W){s5_vel[a][DATA_W-1]}}, s5_vel[a]}
            + {s5_va[a][TERM_W-1], s5_va[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_vel <= s5_vel;
      s6_pv  <= s5_pv;
      s6_ht  <= ht;
      s6_nv  <= nv;
    end
  end

  // ---------------- stage 7: final sums and saturation ----------------
  logic                        s7_valid;
  logic [AXES-1:0][DATA_W-1:0] s7_vel;
  logic [AXES-1:0][DATA_W-1:0] s7_npos;
  logic [AXES-1:0][DATA_W-1:0] s7_nvel;
  logic [AXES-1:0][DATA_W-1:0] npos;
  logic [AXES-1:0][DATA_W-1:0] nvel;

  always_comb begin
    logic [SUM_W-1:0] psum;
    for (int a = 0; a < AXES; a++) begin
      psum    = {s6_pv[a][TERM_W], s6_pv[a]}
              + {{(SUM_W-HMAG_W-1){s6_ht[a][HMAG_W]}}, s6_ht[a]};
      npos[a] = pms_pkg::sat32(psum);
      nvel[a] = pms_pkg::sat32({s6_nv[a][TERM_W], s6_nv[a]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (adv) begin
      s7_valid <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_vel  <= s6_vel;
      s7_npos <= npos;
      s7_nvel <= nvel;
    end
  end

  // ---------------- region test and output queue ----------------
  logic             lost;
  logic             push;
  pms_pkg::result_t result;
  pms_pkg::result_t q_data;

  always_comb begin
    lost = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (s7_npos[a][DATA_W-1] ||
          ($signed(s7_npos[a]) > $signed({1'b0, region_size}))) begin
        lost = 1'b1;
      end
    end
    result.new_pos_x   = s7_npos[0];
    result.new_pos_y   = s7_npos[1];
    // keep the incoming velocity for a lost particle
    result.new_vel_x   = lost ? s7_vel[0] : s7_nvel[0];
    result.new_vel_y   = lost ? s7_vel[1] : s7_nvel[1];
    result.left_region = lost;
  end

  assign push = s7_valid && adv;

  pms_outq #(
    .WIDTH (RES_W)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_data)
  );

  assign new_pos_x   = q_data.new_pos_x;
  assign new_pos_y   = q_data.new_pos_y;
  assign new_vel_x   = q_data.new_vel_x;
  assign new_vel_y   = q_data.new_vel_y;
  assign left_region = q_data.left_region;

  `PMS_ASSERT_NEXT(a_hold_last, clk, rst, s7_valid && !adv, s7_valid && $stable(s7_npos))
  `PMS_ASSERT_SAME(a_stall_has_result, clk, rst, in_stall, out_valid)

endmodule

`default_nettype wire
